### sv/ibus_receive_framer_assert.svh
// Assertion macros shared by the receive framer RTL.
// Needs nothing else; files that assert take it by include.
`ifndef IBUS_RECEIVE_FRAMER_ASSERT_SVH
`define IBUS_RECEIVE_FRAMER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define IRF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define IRF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### sv/irf_pkg.sv
// Types and codes for the receive framer.
// Used by irf_core and ibus_receive_framer; depends on nothing.
package irf_pkg;

    localparam logic [1:0] REQ_RX_BYTE = 2'd0;
    localparam logic [1:0] REQ_TICK    = 2'd1;
    localparam logic [1:0] REQ_TX_SENT = 2'd2;

    localparam logic [2:0] EV_NONE     = 3'd0;
    localparam logic [2:0] EV_STORED   = 3'd1;
    localparam logic [2:0] EV_ECHO     = 3'd2;
    localparam logic [2:0] EV_VALID    = 3'd3;
    localparam logic [2:0] EV_BADSUM   = 3'd4;
    localparam logic [2:0] EV_OVERFLOW = 3'd5;
    localparam logic [2:0] EV_TIMEOUT  = 3'd6;
    localparam logic [2:0] EV_ECHOLOAD = 3'd7;

    localparam logic [7:0] COUNT_LIMIT  = 8'hFE;
    localparam logic [7:0] GAP_MS_RESET = 8'd8;
    localparam logic [7:0] MIN_FRAME    = 8'd4;
    localparam logic [8:0] LEN_EXTRA    = 9'd2;
    localparam logic [7:0] IDLE_MAX     = 8'hFF;

    typedef struct packed {
        logic [1:0] req_type;
        logic [7:0] rx_byte;
        logic [7:0] tx_frame_len;
    } item_t;

    typedef struct packed {
        logic [2:0] event_res;
        logic [7:0] byte_value;
        logic [7:0] byte_index;
        logic       gap_discard;
    } result_t;

endpackage

### sv/irf_core.sv
// Framing state and the per-item update logic of the receive framer.
// Depends on irf_pkg.
module irf_core
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  logic [7:0]      cfg_wdata,
    input  logic            step,
    input  irf_pkg::item_t  item,
    output irf_pkg::result_t result
);

    logic [7:0] gap_ms_reg;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] frame_length_reg, frame_length_next;
    logic [7:0] running_xor_reg, running_xor_next;
    logic [7:0] echo_left_reg, echo_left_next;
    logic [7:0] idle_ms_reg, idle_ms_next;

    logic [7:0] idle_inc;
    logic       held;
    logic       rx_expired;
    logic [7:0] bc0, fl0, x0;
    logic [7:0] fl1, x1, bc1;
    logic [8:0] total;

    always_comb
    begin
        idle_inc   = (idle_ms_reg == irf_pkg::IDLE_MAX) ? idle_ms_reg : idle_ms_reg + 8'd1;
        held       = (byte_count_reg != 8'd0);
        rx_expired = held && (idle_ms_reg >= gap_ms_reg);

        // drop a stale frame before the byte is handled
        bc0 = rx_expired ? 8'd0 : byte_count_reg;
        fl0 = rx_expired ? 8'd0 : frame_length_reg;
        x0  = rx_expired ? 8'd0 : running_xor_reg;

        fl1   = (bc0 == 8'd1) ? item.rx_byte : fl0;
        x1    = x0 ^ item.rx_byte;
        bc1   = bc0 + 8'd1;
        total = {1'b0, fl1} + irf_pkg::LEN_EXTRA;

        byte_count_next   = byte_count_reg;
        frame_length_next = frame_length_reg;
        running_xor_next  = running_xor_reg;
        echo_left_next    = echo_left_reg;
        idle_ms_next      = idle_ms_reg;
        result            = '0;

        case (item.req_type)
            irf_pkg::REQ_TX_SENT:
            begin
                echo_left_next   = item.tx_frame_len + 8'd2;
                result.event_res = irf_pkg::EV_ECHOLOAD;
            end
            irf_pkg::REQ_TICK:
            begin
                idle_ms_next = idle_inc;
                if (held && (idle_inc >= gap_ms_reg))
                begin
                    byte_count_next   = 8'd0;
                    frame_length_next = 8'd0;
                    running_xor_next  = 8'd0;
                    result.event_res  = irf_pkg::EV_TIMEOUT;
                end
            end
            irf_pkg::REQ_RX_BYTE:
            begin
                result.gap_discard = rx_expired;
                idle_ms_next       = 8'd0;
                byte_count_next    = bc0;
                frame_length_next  = fl0;
                running_xor_next   = x0;
                if (echo_left_reg != 8'd0)
                begin
                    echo_left_next   = echo_left_reg - 8'd1;
                    result.event_res = irf_pkg::EV_ECHO;
                end
                else
                begin
                    result.byte_value = item.rx_byte;
                    result.byte_index = bc0;
                    byte_count_next   = bc1;
                    frame_length_next = fl1;
                    running_xor_next  = x1;
                    result.event_res  = irf_pkg::EV_STORED;
                    if ((bc1 > irf_pkg::MIN_FRAME) && ({1'b0, bc1} == total))
                    begin
                        result.event_res  = (x1 == 8'd0) ? irf_pkg::EV_VALID
                                                         : irf_pkg::EV_BADSUM;
                        byte_count_next   = 8'd0;
                        frame_length_next = 8'd0;
                        running_xor_next  = 8'd0;
                    end
                    else if (bc1 > irf_pkg::COUNT_LIMIT)
                    begin
                        result.event_res  = irf_pkg::EV_OVERFLOW;
                        byte_count_next   = 8'd0;
                        frame_length_next = 8'd0;
                        running_xor_next  = 8'd0;
                    end
                end
            end
            default:
            begin
                result.event_res = irf_pkg::EV_NONE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_ms_reg       <= irf_pkg::GAP_MS_RESET;
            byte_count_reg   <= 8'd0;
            frame_length_reg <= 8'd0;
            running_xor_reg  <= 8'd0;
            echo_left_reg    <= 8'd0;
            idle_ms_reg      <= 8'd0;
        end
        else
        begin
            if (cfg_we)
            begin
                gap_ms_reg <= cfg_wdata;
            end
            if (step)
            begin
                byte_count_reg   <= byte_count_next;
                frame_length_reg <= frame_length_next;
                running_xor_reg  <= running_xor_next;
                echo_left_reg    <= echo_left_next;
                idle_ms_reg      <= idle_ms_next;
            end
        end
    end

endmodule

### sv/ibus_receive_framer.sv
// Receive framer top level: input register, framing core, result register.
// Depends on irf_pkg, irf_core and ibus_receive_framer_assert.svh.
//
// Takes one item per cycle while the output is not stalled and gives exactly
// one result item per input item: it is held in the input register, then goes
// through the framing logic and is then written into the result
// register. Input tuser carries the request kind (0 received byte, 1 one
// millisecond tick, 2 own frame sent, 3 ignored); results carry the event
// code in tuser. Both registers may hold an item while the output stalls,
// so the input keeps accepting until both are full. Write gap_ms through
// cfg_we/cfg_wdata only while no item is in flight; it resets to 8.
`include "ibus_receive_framer_assert.svh"

module ibus_receive_framer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte [7:0], tx_frame_len [15:8]
    input  logic [1:0]  s_tuser,   // req_type [1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // byte_value [7:0], byte_index [15:8],
                                   // gap_discard [16], zero [23:17]
    output logic [2:0]  m_tuser    // event_res [2:0]
);

    logic              in_valid_reg;
    irf_pkg::item_t    in_item_reg;
    logic              out_valid_reg;
    irf_pkg::result_t  out_res_reg;
    irf_pkg::result_t  core_res;
    logic              out_free;
    logic              advance;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;

    irf_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .step      (advance),
        .item      (in_item_reg),
        .result    (core_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (out_free)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    // payload: hold while stalled
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_item_reg.req_type     <= s_tuser;
            in_item_reg.rx_byte      <= s_tdata[7:0];
            in_item_reg.tx_frame_len <= s_tdata[15:8];
        end
        if (advance)
        begin
            out_res_reg <= core_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.event_res;
    assign m_tdata  = {7'd0, out_res_reg.gap_discard, out_res_reg.byte_index,
                       out_res_reg.byte_value};

    `IRF_ASSERT_NOW(a_ready_only_when_full, clk, rst_n, !s_tready,
        in_valid_reg && out_valid_reg && !m_tready, "input stalled with room left")
    `IRF_ASSERT_NEXT(a_advance_fills_out, clk, rst_n, advance, out_valid_reg,
        "advanced item did not reach the result register")
    `IRF_ASSERT_NOW(a_index_in_range, clk, rst_n, m_tvalid, m_tdata[15:8] != 8'hFF,
        "byte index beyond frame limit")
    `IRF_ASSERT_NOW(a_echo_no_byte, clk, rst_n,
        m_tvalid && (m_tuser == irf_pkg::EV_ECHO || m_tuser == irf_pkg::EV_TIMEOUT),
        m_tdata[15:0] == 16'd0, "byte fields set on an event without a stored byte")

endmodule

### tb/ibus_receive_framer_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the receive framer: watches the gap register writes and both
// stream ports, predicts one result item per accepted item and compares.
// Depends on irf_pkg only.
module ibus_receive_framer_checker
    import irf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [7:0]  cfg_wdata,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          expected_left,
    output int          fail_count
);

    logic [7:0] gap_ms;
    logic [7:0] byte_count;
    logic [7:0] frame_length;
    logic [7:0] running_xor;
    logic [7:0] echo_left;
    logic [7:0] idle_ms;
    result_t    events_due[$];

    function automatic void clear_frame();
        byte_count   = '0;
        frame_length = '0;
        running_xor  = '0;
    endfunction

    function automatic logic frame_stale();
        return byte_count != 8'd0 && idle_ms >= gap_ms;
    endfunction

    function automatic result_t framer_step(item_t it);
        result_t    r;
        logic [8:0] total;
        r = '0;
        case (it.req_type)
            REQ_TX_SENT:
            begin
                echo_left   = 8'({1'b0, it.tx_frame_len} + LEN_EXTRA);
                r.event_res = EV_ECHOLOAD;
            end
            REQ_TICK:
            begin
                if (idle_ms != IDLE_MAX)
                    idle_ms++;
                if (frame_stale())
                begin
                    clear_frame();
                    r.event_res = EV_TIMEOUT;
                end
            end
            REQ_RX_BYTE:
            begin
                // drop a stale partial frame before the byte is handled
                if (frame_stale())
                begin
                    clear_frame();
                    r.gap_discard = 1'b1;
                end
                idle_ms = '0;
                if (echo_left != 8'd0)
                begin
                    echo_left--;
                    r.event_res = EV_ECHO;
                end
                else
                begin
                    r.byte_value = it.rx_byte;
                    r.byte_index = byte_count;
                    if (byte_count == 8'd1)
                        frame_length = it.rx_byte;
                    running_xor = running_xor ^ it.rx_byte;
                    byte_count++;
                    total       = {1'b0, frame_length} + LEN_EXTRA;
                    r.event_res = EV_STORED;
                    if (byte_count > MIN_FRAME && {1'b0, byte_count} == total)
                    begin
                        r.event_res = (running_xor == 8'd0) ? EV_VALID : EV_BADSUM;
                        clear_frame();
                    end
                    else if (byte_count > COUNT_LIMIT)
                    begin
                        r.event_res = EV_OVERFLOW;
                        clear_frame();
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic check_field(input string name, input logic [7:0] expv,
                               input logic [7:0] gotv);
        if (gotv !== expv)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, gotv);
            fail_count++;
        end
    endtask

    always @(posedge clk)
    begin : watch
        item_t   in_item;
        result_t due;
        if (!rst_n)
        begin
            gap_ms    = GAP_MS_RESET;
            echo_left = '0;
            idle_ms   = '0;
            clear_frame();
            events_due.delete();
            expected_left = 0;
        end
        else
        begin
            if (cfg_we)
                gap_ms = cfg_wdata;
            if (s_tvalid && s_tready)
            begin
                in_item.req_type     = s_tuser;
                in_item.rx_byte      = s_tdata[7:0];
                in_item.tx_frame_len = s_tdata[15:8];
                events_due.push_back(framer_step(in_item));
            end
            if (m_tvalid && m_tready)
            begin
                if (events_due.size() == 0)
                begin
                    $error("result item with nothing expected: event_res %0d", m_tuser);
                    fail_count++;
                end
                else
                begin
                    due = events_due.pop_front();
                    check_field("event_res", 8'(due.event_res), 8'(m_tuser));
                    check_field("byte_value", due.byte_value, m_tdata[7:0]);
                    check_field("byte_index", due.byte_index, m_tdata[15:8]);
                    check_field("gap_discard", 8'(due.gap_discard), 8'(m_tdata[16]));
                end
            end
            expected_left = events_due.size();
        end
    end

endmodule

### tb/ibus_receive_framer_tb.sv
`timescale 1ns / 1ps
// Testbench top for the receive framer: clock, reset, gap register writes and
// item stimulus under several idling phases; checking is in the checker.
// Depends on irf_pkg, ibus_receive_framer and ibus_receive_framer_checker.
module ibus_receive_framer_tb;
    import irf_pkg::*;

    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 300000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [2:0]  m_tuser;
    int          expected_left;
    int          fail_count;

    int         src_idle_pct   = 0;
    int         sink_stall_pct = 0;
    int         hold_left      = 0;
    int         sent_count     = 0;
    int         cycle_count    = 0;
    logic [7:0] cur_gap        = GAP_MS_RESET;

    ibus_receive_framer i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    ibus_receive_framer_checker i_checker
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .m_tuser       (m_tuser),
        .expected_left (expected_left),
        .fail_count    (fail_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("ibus_receive_framer test failed");
        $finish;
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // Offer one item from a falling edge; return at the falling edge after
    // it was taken. Fields the request kind does not use get random values.
    task automatic push_item(input logic [1:0] kind, input logic [7:0] value);
        logic [7:0] rx;
        logic [7:0] txl;
        rx  = 8'($urandom);
        txl = 8'($urandom);
        if (kind == REQ_RX_BYTE)
            rx = value;
        if (kind == REQ_TX_SENT)
            txl = value;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {txl, rx};
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (kind != REQ_UNUSED)
            sent_count++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_left != 0)
            @(negedge clk);
    endtask

    task automatic write_gap(input logic [7:0] value);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we  <= 1'b0;
        cur_gap = value;
    endtask

    // Ticks inside a frame, kept below the gap so the frame survives.
    task automatic frame_ticks();
        if (cur_gap > 8'd1 && $urandom_range(99) < 15)
            repeat ($urandom_range(1, (cur_gap > 8'd6) ? 5 : cur_gap - 1))
                push_item(REQ_TICK, 8'h00);
    endtask

    // Sender, length, body, checksum: length + 2 bytes in all.
    task automatic send_frame(input logic [7:0] len, input logic corrupt);
        logic [7:0] sum;
        logic [7:0] b;
        sum = '0;
        for (int i = 0; i <= len; i++)
        begin
            b = (i == 1) ? len : 8'($urandom);
            if (i > 0)
                frame_ticks();
            push_item(REQ_RX_BYTE, b);
            sum = sum ^ b;
        end
        frame_ticks();
        if (corrupt)
            sum = sum ^ 8'($urandom_range(1, 255));
        push_item(REQ_RX_BYTE, sum);
    endtask

    task automatic random_burst();
        int pick;
        int n;
        pick = $urandom_range(99);
        if (pick < 50)
            send_frame(($urandom_range(99) < 85) ? 8'($urandom_range(3, 12))
                                                 : 8'($urandom_range(13, 40)),
                       $urandom_range(99) < 15);
        else if (pick < 62)
        begin
            // own frame sent, then its echo
            n = $urandom_range(0, 6);
            push_item(REQ_TX_SENT, 8'(n));
            repeat (n + 2)
                push_item(REQ_RX_BYTE, 8'($urandom));
        end
        else if (pick < 77)
        begin
            // partial frame, left to go stale when the gap is 20 or less
            repeat ($urandom_range(1, 4))
                push_item(REQ_RX_BYTE, 8'($urandom));
            n = (cur_gap <= 8'd20) ? cur_gap + $urandom_range(0, 2) : $urandom_range(1, 3);
            repeat (n)
                push_item(REQ_TICK, 8'h00);
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                push_item(2'($urandom_range(0, 3)), 8'($urandom));
            // a length of 254 wraps the echo count to zero
            push_item(REQ_TX_SENT, 8'd254);
        end
    endtask

    task automatic run_random(input int count);
        int target;
        target = sent_count + count;
        while (sent_count < target)
            random_burst();
    endtask

    initial
    begin
        logic [7:0] good_frame [5];
        logic [7:0] bad_frame [5];
        good_frame = '{8'hFF, 8'h03, 8'h00, 8'h80, 8'h7C};
        bad_frame  = '{8'h00, 8'h03, 8'hFF, 8'h01, 8'hFE};
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = REQ_RX_BYTE;
        repeat (7)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed part, gap at its reset value
        push_item(REQ_UNUSED, 8'hFF);
        push_item(REQ_TICK, 8'h00);
        push_item(REQ_TX_SENT, 8'd1);
        push_item(REQ_RX_BYTE, 8'h00);
        push_item(REQ_RX_BYTE, 8'hFF);
        push_item(REQ_RX_BYTE, 8'h5A);
        push_item(REQ_TX_SENT, 8'd255);
        push_item(REQ_RX_BYTE, 8'hFF);
        foreach (good_frame[i])
            push_item(REQ_RX_BYTE, good_frame[i]);
        foreach (bad_frame[i])
            push_item(REQ_RX_BYTE, bad_frame[i]);
        // zero length never completes; let it time out
        push_item(REQ_RX_BYTE, 8'h12);
        push_item(REQ_RX_BYTE, 8'h00);
        push_item(REQ_RX_BYTE, 8'h34);
        repeat (8)
            push_item(REQ_TICK, 8'h00);
        run_random(15);

        write_gap(8'd1);
        src_idle_pct = 70;
        run_random(15);

        write_gap(8'd255);
        src_idle_pct   = 0;
        sink_stall_pct = 70;
        // lower the gap under a held partial frame so the next byte drops it
        push_item(REQ_RX_BYTE, 8'h40);
        push_item(REQ_RX_BYTE, 8'h0A);
        repeat (12)
            push_item(REQ_TICK, 8'h00);
        write_gap(8'd10);
        push_item(REQ_RX_BYTE, 8'h55);
        write_gap(8'd255);
        // short length after the sender above: run into the count limit
        push_item(REQ_RX_BYTE, 8'h01);
        repeat (253)
            push_item(REQ_RX_BYTE, 8'($urandom));
        run_random(15);

        write_gap(8'd3);
        src_idle_pct   = 27;
        sink_stall_pct = 27;
        run_random(10);
        // hold the result side off and keep offering until the input stalls
        s_tvalid <= 1'b0;
        @(posedge clk);
        hold_left = 60;
        @(negedge clk);
        src_idle_pct = 0;
        send_frame(8'd12, 1'b0);
        wait_drained();
        src_idle_pct = 27;
        run_random(10);

        write_gap(8'd0);
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        run_random(10);

        write_gap(8'd20);
        src_idle_pct   = 27;
        sink_stall_pct = 27;
        run_random(15);

        wait_drained();
        repeat (10)
            @(negedge clk);
        if (fail_count == 0 && expected_left == 0)
            $display("ibus_receive_framer test passed");
        else
            $display("ibus_receive_framer test failed");
        $finish;
    end

endmodule
